/* rtl/core/sbhp_pkg.sv */
// Shared types and constants for the selection buffer hit picker.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package sbhp_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RANK_W  = 8;
  localparam int unsigned COUNT_W = 6;
  // Internal hit counter; saturates well above any rank or reported count.
  localparam int unsigned HIT_W   = 8;

  localparam logic [HIT_W-1:0]   HIT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_MIN,
    PH_MAX,
    PH_NAME,
    PH_SKIP
  } sbhp_phase_t;

  typedef struct packed {
    logic [WORD_W-1:0]        word;
    logic                     first_word;
    logic                     last_word;
    logic signed [RANK_W-1:0] rank;
  } sbhp_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]  selected_id;
    logic [COUNT_W-1:0] hit_count;
  } sbhp_result_t;

endpackage

/* rtl/core/sbhp_in_stage.sv */
// Input register for the hit picker: holds one buffer beat until the
// parser takes it. Depends on sbhp_pkg.
`timescale 1ns / 1ps

module sbhp_in_stage import sbhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sbhp_beat_t in_beat,
  input  logic       advance,
  output logic       beat_valid,
  output sbhp_beat_t beat
);

  logic       valid_r;
  sbhp_beat_t beat_r;

  // Hold a beat only while the parser cannot take it.
  assign in_stall   = valid_r && !advance;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r <= in_beat;
    end
  end

endmodule

/* rtl/core/sbhp_parse_core.sv */
// Record parser and hit selection state for the hit picker.
// Depends on sbhp_pkg; one beat is parsed per go cycle.
`timescale 1ns / 1ps

module sbhp_parse_core import sbhp_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  sbhp_beat_t   beat,
  output logic         res_valid,
  output sbhp_result_t res
);

  localparam int unsigned WIDX_W = $clog2(BUFFER_WORDS + 1);
  localparam logic [WIDX_W-1:0] WIDX_END = WIDX_W'(BUFFER_WORDS);

  sbhp_phase_t              phase_r, phase_nxt;
  logic [WIDX_W-1:0]        names_r, names_nxt;
  logic                     done_r, done_nxt;
  logic [HIT_W-1:0]         hits_r, hits_nxt;
  logic [WORD_W-1:0]        best_id_r, best_id_nxt;
  logic [WORD_W-1:0]        best_min_r, best_min_nxt;
  logic [WORD_W-1:0]        best_max_r, best_max_nxt;
  logic [WORD_W-1:0]        pend_id_r, pend_id_nxt;
  logic [WORD_W-1:0]        pend_min_r, pend_min_nxt;
  logic [WORD_W-1:0]        pend_max_r, pend_max_nxt;
  logic signed [RANK_W-1:0] rank_r, rank_nxt;
  logic [WIDX_W-1:0]        widx_r, widx_nxt;
  logic                     commit;
  logic [WORD_W-1:0]        count_m1;

  assign count_m1 = beat.word - WORD_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    names_nxt    = names_r;
    done_nxt     = done_r;
    hits_nxt     = hits_r;
    best_id_nxt  = best_id_r;
    best_min_nxt = best_min_r;
    best_max_nxt = best_max_r;
    pend_id_nxt  = pend_id_r;
    pend_min_nxt = pend_min_r;
    pend_max_nxt = pend_max_r;
    rank_nxt     = rank_r;
    widx_nxt     = widx_r;
    commit       = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    if (go) begin
      if (beat.first_word) begin
        phase_nxt    = PH_COUNT;
        names_nxt    = '0;
        done_nxt     = 1'b0;
        hits_nxt     = '0;
        best_id_nxt  = '0;
        best_min_nxt = '0;
        best_max_nxt = '0;
        pend_id_nxt  = '0;
        pend_min_nxt = '0;
        pend_max_nxt = '0;
        widx_nxt     = '0;
        rank_nxt     = beat.rank;
      end

      if (!done_nxt) begin
        if (widx_nxt < WIDX_END) begin
          unique case (phase_nxt)
            PH_COUNT: begin
              if (beat.word == '0) begin
                done_nxt = 1'b1;
              end else begin
                // A name run longer than the buffer never ends; clamp it.
                if (count_m1 >= WORD_W'(BUFFER_WORDS)) begin
                  names_nxt = WIDX_END;
                end else begin
                  names_nxt = count_m1[WIDX_W-1:0];
                end
                phase_nxt = PH_MIN;
              end
            end
            PH_MIN: begin
              pend_min_nxt = beat.word;
              phase_nxt    = PH_MAX;
            end
            PH_MAX: begin
              pend_max_nxt = beat.word;
              phase_nxt    = PH_NAME;
            end
            PH_NAME: begin
              pend_id_nxt = beat.word;
              if (names_nxt == '0) begin
                commit    = 1'b1;
                phase_nxt = PH_COUNT;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
            default: begin
              if (names_nxt != '0) begin
                names_nxt = names_nxt - WIDX_W'(1);
              end
              if (names_nxt == '0) begin
                commit    = 1'b1;
                phase_nxt = PH_COUNT;
              end
            end
          endcase
        end else begin
          done_nxt = 1'b1;
        end
      end

      if (commit) begin
        if (hits_nxt == '0) begin
          best_id_nxt  = pend_id_nxt;
          best_min_nxt = pend_min_nxt;
          best_max_nxt = pend_max_nxt;
        end else if (rank_nxt == '0 && pend_min_nxt < best_min_nxt) begin
          best_min_nxt = pend_min_nxt;
          best_id_nxt  = pend_id_nxt;
        end else if (rank_nxt[RANK_W-1] && pend_max_nxt > best_max_nxt) begin
          best_max_nxt = pend_max_nxt;
          best_id_nxt  = pend_id_nxt;
        end else if (!rank_nxt[RANK_W-1] && rank_nxt != '0 &&
                     {1'b0, hits_nxt} + (HIT_W+1)'(1) ==
                     (HIT_W+1)'($unsigned(rank_nxt))) begin
          best_id_nxt = pend_id_nxt;
        end
        if (hits_nxt != HIT_MAX) begin
          hits_nxt = hits_nxt + HIT_W'(1);
        end
      end

      if (widx_nxt != WIDX_END) begin
        widx_nxt = widx_nxt + WIDX_W'(1);
      end

      if (beat.last_word) begin
        res_valid       = 1'b1;
        res.selected_id = best_id_nxt;
        res.hit_count   = (hits_nxt > HIT_W'(COUNT_MAX)) ? COUNT_MAX
                                                         : hits_nxt[COUNT_W-1:0];
        done_nxt        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      names_r    <= '0;
      done_r     <= 1'b0;
      hits_r     <= '0;
      best_id_r  <= '0;
      best_min_r <= '0;
      best_max_r <= '0;
      pend_id_r  <= '0;
      pend_min_r <= '0;
      pend_max_r <= '0;
      rank_r     <= '0;
      widx_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      names_r    <= names_nxt;
      done_r     <= done_nxt;
      hits_r     <= hits_nxt;
      best_id_r  <= best_id_nxt;
      best_min_r <= best_min_nxt;
      best_max_r <= best_max_nxt;
      pend_id_r  <= pend_id_nxt;
      pend_min_r <= pend_min_nxt;
      pend_max_r <= pend_max_nxt;
      rank_r     <= rank_nxt;
      widx_r     <= widx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    go && beat.last_word |=> done_r)
    else $error("parser still active after the last beat");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && beat.first_word) |=> hits_r >= $past(hits_r))
    else $error("hit count dropped without a new buffer");

  a_widx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= WIDX_END)
    else $error("word index ran past the buffer size");
`endif

endmodule

/* rtl/core/sbhp_out_stage.sv */
// Result register for the hit picker: holds one result beat until taken.
// Depends on sbhp_pkg.
`timescale 1ns / 1ps

module sbhp_out_stage import sbhp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  sbhp_result_t res,
  output logic         out_free,
  output logic         out_valid,
  input  logic         out_stall,
  output sbhp_result_t out_res
);

  logic         valid_r;
  sbhp_result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/core/select_buffer_hit_picker.sv */
// Top level of the selection buffer hit picker.
// Depends on sbhp_pkg, sbhp_in_stage, sbhp_parse_core and sbhp_out_stage.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  word, first_word, last_word, rank
//   out_     output     out_valid / out_stall selected_id, hit_count
//
// One word per cycle unless stalled; a result passes the input register, then the result register.
// The parser computes all record state updates combinationally from the input register.
// Reset is synchronous, active low, and clears parse state to no hits.
// A stalled result blocks the input only when the next parsed beat is a last word.
`timescale 1ns / 1ps

module select_buffer_hit_picker import sbhp_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [WORD_W-1:0]        in_word,
  input  logic                     in_first_word,
  input  logic                     in_last_word,
  input  logic signed [RANK_W-1:0] in_rank,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        out_selected_id,
  output logic [COUNT_W-1:0]       out_hit_count
);

  sbhp_beat_t   in_beat;
  sbhp_beat_t   beat;
  logic         beat_valid;
  logic         advance;
  logic         go;
  logic         out_free;
  logic         res_valid;
  sbhp_result_t res;
  sbhp_result_t out_res;

  assign in_beat.word       = in_word;
  assign in_beat.first_word = in_first_word;
  assign in_beat.last_word  = in_last_word;
  assign in_beat.rank       = in_rank;

  // A beat that makes a result needs a free result slot.
  assign advance = !beat.last_word || out_free;
  assign go      = beat_valid && advance;

  sbhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sbhp_parse_core #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  sbhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_selected_id = out_res.selected_id;
  assign out_hit_count   = out_res.hit_count;

`ifndef SYNTHESIS
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> beat_valid && beat.last_word && out_valid)
    else $error("input stalled without a blocked last beat");
`endif

endmodule
